// File: design/bccmc_pkg.sv
// Shared constants, codes and controller/datapath interface types for the coin change block.
`default_nettype none
package bccmc_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;   // slot or level index
  localparam int LW = $clog2(NUM_SLOTS + 1);                        // level count 0..NUM_SLOTS
  localparam int DW = 16;
  localparam int TW = 20;
  localparam logic [TW-1:0] TOTAL_ONES = {TW{1'b1}};

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CHANGE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NOEX = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic capture;
    logic add;
    logic query;
    logic zero_chg;
    logic fail_out;
    logic chg_init;
    logic sort_pick;
    logic record;
    logic div_start;
    logic set_cnt;
    logic mul;
    logic descend;
    logic up;
    logic dec;
    logic emit_init;
    logic emit_out;
    logic emit_next;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       amount_zero;
    logic       out_free;
    logic       sort_found;
    logic       rem_zero;
    logic       at_bottom;
    logic       prune;
    logic       div_done;
    logic       k_zero;
    logic       cnt_zero;
    logic       have_best;
    logic       emit_nz;
    logic       emit_last;
  } dp_sts_t;

endpackage
`default_nettype wire

// File: design/bccmc_div.sv
// Restoring 16-bit unsigned divider, one quotient bit per cycle.
`default_nettype none
module bccmc_div (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [bccmc_pkg::DW-1:0] dividend_i,
  input  wire logic [bccmc_pkg::DW-1:0] divisor_i,
  output logic                         done_o,
  output logic [bccmc_pkg::DW-1:0]     quot_o
);

  localparam int CW = $clog2(bccmc_pkg::DW + 1);

  logic [bccmc_pkg::DW-1:0] rem_q, rem_d, quo_q, quo_d, div_q, div_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic                     busy_q, busy_d, done_q, done_d;
  logic [bccmc_pkg::DW:0]   r_sh;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    r_sh   = {rem_q, quo_q[bccmc_pkg::DW-1]};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (r_sh >= {1'b0, div_q}) begin
        rem_d = bccmc_pkg::DW'(r_sh - {1'b0, div_q});
        quo_d = {quo_q[bccmc_pkg::DW-2:0], 1'b1};
      end else begin
        rem_d = r_sh[bccmc_pkg::DW-1:0];
        quo_d = {quo_q[bccmc_pkg::DW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(bccmc_pkg::DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

// File: design/bccmc_dpath.sv
// Datapath: coin inventory, search stack, best solution and output register.
`default_nettype none
module bccmc_dpath (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire bccmc_pkg::ctrl_cmd_t   cmd_i,
  output bccmc_pkg::dp_sts_t          sts_o,
  input  wire logic [1:0]             op_i,
  input  wire logic [47:0]            in_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [31:0]                 out_data_o,
  output logic [2:0]                  out_user_o,
  output logic                        out_last_o
);

  localparam int N  = bccmc_pkg::NUM_SLOTS;
  localparam int IW = bccmc_pkg::IW;
  localparam int LW = bccmc_pkg::LW;
  localparam int DW = bccmc_pkg::DW;
  localparam int TW = bccmc_pkg::TW;

  // inventory
  logic [N-1:0]  valid_q;
  logic [DW-1:0] value_q [N];
  logic [DW-1:0] stock_q [N];

  // captured item
  logic [DW-1:0] denom_q, delta_q, amount_q;

  // search state
  logic [LW-1:0] m_q, k_q;
  logic [DW:0]   prev_q;
  logic [IW-1:0] ord_q   [N];
  logic [DW-1:0] cnt_q   [N];
  logic [DW-1:0] rem_q   [N+1];
  logic [TW-1:0] coins_q [N+1];
  logic [DW-1:0] bcnt_q  [N];
  logic [TW-1:0] best_q;
  logic [2*DW-1:0] prod_q;

  // output register
  logic          ovalid_q;
  logic [1:0]    ost_q;
  logic [DW-1:0] oval_q, ocnt_q;
  logic          onone_q, olast_q;

  logic [IW-1:0] kx, mx, ord_k;
  logic [LW-1:0] kp1;
  logic [DW-1:0] d_k, stock_k;
  assign kx      = k_q[IW-1:0];
  assign mx      = m_q[IW-1:0];
  assign kp1     = k_q + 1'b1;
  assign ord_k   = ord_q[kx];
  assign d_k     = value_q[ord_k];
  assign stock_k = stock_q[ord_k];

  // slot lookup for add and query
  logic          hit, free_found;
  logic [IW-1:0] hit_idx, free_idx, slot_sel;
  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    free_found = 1'b0;
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (valid_q[i] && value_q[i] == denom_q) begin
        hit = 1'b1;
        hit_idx = IW'(i);
      end
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx = IW'(i);
      end
    end
  end
  assign slot_sel = hit ? hit_idx : free_idx;

  logic [DW-1:0]        stock_cur, stock_new;
  logic signed [DW+1:0] sum;
  logic                 full;
  assign stock_cur = hit ? stock_q[hit_idx] : '0;
  assign sum = $signed({2'b00, stock_cur}) + $signed({{2{delta_q[DW-1]}}, delta_q});
  assign full = !hit && !free_found;
  always_comb begin
    if (sum < 0) stock_new = '0;
    else if (sum > $signed({2'b00, {DW{1'b1}}})) stock_new = {DW{1'b1}};
    else stock_new = sum[DW-1:0];
  end

  // next denomination in descending order
  logic          sf;
  logic [IW-1:0] s_idx;
  logic [DW-1:0] s_val;
  always_comb begin
    sf = 1'b0;
    s_idx = '0;
    s_val = '0;
    for (int i = 0; i < N; i++) begin
      if (valid_q[i] && stock_q[i] != '0 && value_q[i] != '0 &&
          {1'b0, value_q[i]} < prev_q && (!sf || value_q[i] > s_val)) begin
        sf = 1'b1;
        s_idx = IW'(i);
        s_val = value_q[i];
      end
    end
  end

  logic emit_last;
  always_comb begin
    emit_last = 1'b1;
    for (int j = 0; j < N; j++)
      if (LW'(j) < k_q && bcnt_q[j] != '0) emit_last = 1'b0;
  end

  logic          div_done;
  logic [DW-1:0] quot;
  bccmc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rem_q[k_q]),
    .divisor_i  (d_k),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  logic out_free;
  assign out_free = !ovalid_q || out_ready_i;

  always_comb begin
    sts_o.op          = op_i;
    sts_o.amount_zero = (amount_q == '0);
    sts_o.out_free    = out_free;
    sts_o.sort_found  = sf;
    sts_o.rem_zero    = (rem_q[k_q] == '0);
    sts_o.at_bottom   = (k_q == m_q);
    sts_o.prune       = (coins_q[k_q] >= best_q);
    sts_o.div_done    = div_done;
    sts_o.k_zero      = (k_q == '0);
    sts_o.cnt_zero    = (cnt_q[kx] == '0);
    sts_o.have_best   = (best_q != bccmc_pkg::TOTAL_ONES);
    sts_o.emit_nz     = (bcnt_q[kx] != '0);
    sts_o.emit_last   = emit_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      ovalid_q <= 1'b0;
      best_q   <= bccmc_pkg::TOTAL_ONES;
      m_q      <= '0;
      k_q      <= '0;
      for (int i = 0; i < N; i++) stock_q[i] <= '0;
    end else begin
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      if (cmd_i.add || cmd_i.query || cmd_i.zero_chg || cmd_i.fail_out || cmd_i.emit_out)
        ovalid_q <= 1'b1;
      if (cmd_i.add && !full) begin
        valid_q[slot_sel] <= 1'b1;
        stock_q[slot_sel] <= stock_new;
      end
      if (cmd_i.chg_init) begin
        m_q    <= '0;
        k_q    <= '0;
        best_q <= bccmc_pkg::TOTAL_ONES;
      end
      if (cmd_i.sort_pick) m_q <= m_q + 1'b1;
      if (cmd_i.record && coins_q[k_q] < best_q) best_q <= coins_q[k_q];
      if (cmd_i.descend || cmd_i.dec) k_q <= kp1;
      if (cmd_i.up || cmd_i.emit_next) k_q <= k_q - 1'b1;
      if (cmd_i.emit_init) k_q <= m_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      denom_q  <= in_data_i[15:0];
      delta_q  <= in_data_i[31:16];
      amount_q <= in_data_i[47:32];
    end
    if (cmd_i.add && !full) value_q[slot_sel] <= denom_q;
    if (cmd_i.chg_init) begin
      prev_q     <= {1'b1, {DW{1'b0}}};
      rem_q[0]   <= amount_q;
      coins_q[0] <= '0;
    end
    if (cmd_i.sort_pick) begin
      ord_q[mx] <= s_idx;
      prev_q    <= {1'b0, s_val};
    end
    if (cmd_i.record && coins_q[k_q] < best_q)
      for (int j = 0; j < N; j++) bcnt_q[j] <= (LW'(j) < k_q) ? cnt_q[j] : '0;
    if (cmd_i.set_cnt) cnt_q[kx] <= (quot > stock_k) ? stock_k : quot;
    if (cmd_i.mul) prod_q <= cnt_q[kx] * d_k;
    if (cmd_i.descend) begin
      rem_q[kp1]   <= rem_q[k_q] - prod_q[DW-1:0];
      coins_q[kp1] <= coins_q[k_q] + TW'(cnt_q[kx]);
    end
    if (cmd_i.dec) begin
      cnt_q[kx]    <= cnt_q[kx] - 1'b1;
      rem_q[kp1]   <= rem_q[kp1] + d_k;
      coins_q[kp1] <= coins_q[kp1] - 1'b1;
    end
    if (cmd_i.add) begin
      ost_q   <= full ? bccmc_pkg::ST_FULL : bccmc_pkg::ST_OK;
      oval_q  <= denom_q;
      ocnt_q  <= full ? '0 : stock_new;
      onone_q <= 1'b0;
      olast_q <= 1'b1;
    end
    if (cmd_i.query) begin
      ost_q   <= bccmc_pkg::ST_OK;
      oval_q  <= denom_q;
      ocnt_q  <= stock_cur;
      onone_q <= 1'b0;
      olast_q <= 1'b1;
    end
    if (cmd_i.zero_chg || cmd_i.fail_out) begin
      ost_q   <= cmd_i.fail_out ? bccmc_pkg::ST_NOEX : bccmc_pkg::ST_OK;
      oval_q  <= '0;
      ocnt_q  <= '0;
      onone_q <= cmd_i.zero_chg;
      olast_q <= 1'b1;
    end
    if (cmd_i.emit_out) begin
      ost_q   <= bccmc_pkg::ST_OK;
      oval_q  <= d_k;
      ocnt_q  <= bcnt_q[kx];
      onone_q <= 1'b0;
      olast_q <= emit_last;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = {ocnt_q, oval_q};
  assign out_user_o  = {onone_q, ost_q};
  assign out_last_o  = olast_q;

endmodule
`default_nettype wire

// File: design/bccmc_ctrl.sv
// Controller: sequences operations and the depth-first change search.
`default_nettype none
module bccmc_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire bccmc_pkg::dp_sts_t   sts_i,
  output bccmc_pkg::ctrl_cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ADD   = 4'd1;
  localparam logic [3:0] S_QRY   = 4'd2;
  localparam logic [3:0] S_CHG   = 4'd3;
  localparam logic [3:0] S_SORT  = 4'd4;
  localparam logic [3:0] S_ENTER = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_DESC  = 4'd8;
  localparam logic [3:0] S_RET   = 4'd9;
  localparam logic [3:0] S_BACK  = 4'd10;
  localparam logic [3:0] S_EMIT0 = 4'd11;
  localparam logic [3:0] S_EMIT  = 4'd12;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (sts_i.op)
            bccmc_pkg::OP_ADD:    state_d = S_ADD;
            bccmc_pkg::OP_QUERY:  state_d = S_QRY;
            bccmc_pkg::OP_CHANGE: state_d = S_CHG;
            default:              state_d = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (sts_i.out_free) begin
          cmd_o.add = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_QRY: begin
        if (sts_i.out_free) begin
          cmd_o.query = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_CHG: begin
        if (sts_i.amount_zero) begin
          if (sts_i.out_free) begin
            cmd_o.zero_chg = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.chg_init = 1'b1;
          state_d = S_SORT;
        end
      end
      S_SORT: begin
        if (sts_i.sort_found) cmd_o.sort_pick = 1'b1;
        else state_d = S_ENTER;
      end
      S_ENTER: begin
        if (sts_i.rem_zero) begin
          cmd_o.record = 1'b1;
          state_d = S_RET;
        end else if (sts_i.at_bottom || sts_i.prune) begin
          state_d = S_RET;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.set_cnt = 1'b1;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_DESC;
      end
      S_DESC: begin
        cmd_o.descend = 1'b1;
        state_d = S_ENTER;
      end
      S_RET: begin
        if (sts_i.k_zero) state_d = S_EMIT0;
        else begin
          cmd_o.up = 1'b1;
          state_d = S_BACK;
        end
      end
      S_BACK: begin
        // try one coin fewer at this level, else unwind
        if (sts_i.cnt_zero) state_d = S_RET;
        else begin
          cmd_o.dec = 1'b1;
          state_d = S_ENTER;
        end
      end
      S_EMIT0: begin
        if (!sts_i.have_best) begin
          if (sts_i.out_free) begin
            cmd_o.fail_out = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.emit_init = 1'b1;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!sts_i.emit_nz) cmd_o.emit_next = 1'b1;
        else if (sts_i.out_free) begin
          cmd_o.emit_out = 1'b1;
          if (sts_i.emit_last) state_d = S_IDLE;
          else cmd_o.emit_next = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule
`default_nettype wire

// File: design/bounded_coin_change_min_coins.sv
// Add/query: the result is written to the output register once it is free, then the block returns to idle.
// Change: usable slots are sorted one at a time, then a depth-first search over counts runs,
// each visited node using the divider, a multiply and a descend step; total depends on stock.
// Results leave at most one per cycle, while the receiver is ready, through a single output register.
// Reset clears slot valid bits, stock and the best total; no clearing pass.
// Top level of the bounded coin change block.
`default_nettype none
module bounded_coin_change_min_coins (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [47:0] s_axis_tdata_i,   // denomination, coin_delta, amount
  input  wire logic [1:0]  s_axis_tuser_i,   // operation
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // coin_value, coin_count
  output logic [2:0]       m_axis_tuser_o,   // status, no_coins
  output logic             m_axis_tlast_o
);

  bccmc_pkg::ctrl_cmd_t cmd;
  bccmc_pkg::dp_sts_t   sts;

  bccmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bccmc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (s_axis_tuser_i),
    .in_data_i   (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule
`default_nettype wire

// File: design/bccmc_checker.sv
// Port-level checker for the coin change block, bound to the top level.
`default_nettype none
module bccmc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [1:0]  s_axis_tuser_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o,
  input wire logic [2:0]  m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output data changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i <= bccmc_pkg::OP_CHANGE
      |=> !s_axis_tready_o)
    else $error("input taken while an operation is in progress");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1:0] != bccmc_pkg::ST_OK |-> m_axis_tlast_o)
    else $error("error result not marked last");

  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[2] |->
      m_axis_tlast_o && m_axis_tuser_o[1:0] == bccmc_pkg::ST_OK && m_axis_tdata_o == 32'd0)
    else $error("empty change result malformed");

endmodule

bind bounded_coin_change_min_coins bccmc_checker u_bccmc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
`default_nettype wire

// File: tb/bounded_coin_change_min_coins_tb.sv
// Self-checking testbench for the coin inventory and fewest-coin change block.
`default_nettype none
module bounded_coin_change_min_coins_tb;

  typedef struct {
    logic [1:0]         op;
    logic [15:0]        denom;
    logic signed [15:0] delta;
    logic [15:0]        amount;
    bit                 drain;
  } coin_req_t;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] value;
    logic [15:0] count;
    logic        no_coins;
    logic        last;
  } payout_t;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int INF_COINS = 32'h100000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [47:0] s_data = '0;
  logic [1:0]  s_user = '0;
  logic        m_ready = 1'b0;
  wire         s_ready;
  wire         m_valid;
  wire  [31:0] m_data;
  wire  [2:0]  m_user;
  wire         m_last;

  bounded_coin_change_min_coins DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user), .m_axis_tlast_o(m_last)
  );

  coin_req_t pending_reqs[$];
  payout_t   expected_payouts[$];
  int        errors = 0;

  // inventory mirror
  bit          inv_valid[bccmc_pkg::NUM_SLOTS];
  logic [15:0] inv_value[bccmc_pkg::NUM_SLOTS];
  logic [15:0] inv_stock[bccmc_pkg::NUM_SLOTS];
  int          fewest[0:bccmc_pkg::NUM_SLOTS][0:65535];

  initial forever #4 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic payout_t payout(logic [1:0] st, logic [15:0] v, logic [15:0] c,
                                     logic nc, logic l);
    payout_t p;
    p.status = st; p.value = v; p.count = c; p.no_coins = nc; p.last = l;
    return p;
  endfunction

  task automatic enqueue_payout(input payout_t p);
    expected_payouts = {expected_payouts, p};
  endtask

  function automatic int find_denom(logic [15:0] d);
    for (int i = 0; i < bccmc_pkg::NUM_SLOTS; i++)
      if (inv_valid[i] && inv_value[i] == d) return i;
    return -1;
  endfunction

  task automatic predict_change(input int amt);
    int order[bccmc_pkg::NUM_SLOTS];
    int used[bccmc_pkg::NUM_SLOTS];
    int m, p, d, s, c, g, best, rem, n, last_k;
    m = 0;
    if (amt == 0) begin
      enqueue_payout(payout(bccmc_pkg::ST_OK, 0, 0, 1'b1, 1'b1));
      return;
    end
    // sort usable slots, largest denomination first
    for (int i = 0; i < bccmc_pkg::NUM_SLOTS; i++) begin
      if (inv_valid[i] && inv_stock[i] > 0 && inv_value[i] > 0) begin
        p = m;
        while (p > 0 && inv_value[order[p-1]] < inv_value[i]) begin
          order[p] = order[p-1];
          p--;
        end
        order[p] = i;
        m++;
      end
    end
    for (int a = 0; a <= amt; a++) fewest[m][a] = INF_COINS;
    fewest[m][0] = 0;
    for (int k = m - 1; k >= 0; k--) begin
      d = inv_value[order[k]];
      s = inv_stock[order[k]];
      for (int a = 0; a <= amt; a++) begin
        best = INF_COINS;
        for (c = 0; c <= s && c * d <= a; c++) begin
          g = fewest[k+1][a - c*d];
          if (g < INF_COINS && g + c < best) best = g + c;
        end
        fewest[k][a] = best;
      end
    end
    if (fewest[0][amt] >= INF_COINS) begin
      enqueue_payout(payout(bccmc_pkg::ST_NOEX, 0, 0, 1'b0, 1'b1));
      return;
    end
    rem = amt;
    for (int k = 0; k < m; k++) begin
      d = inv_value[order[k]];
      c = rem / d;
      if (c > inv_stock[order[k]]) c = inv_stock[order[k]];
      // take the most coins of this denomination that still reaches the optimum
      while (1) begin
        g = fewest[k+1][rem - c*d];
        if ((g < INF_COINS && g + c == fewest[k][rem]) || c == 0) break;
        c--;
      end
      used[k] = c;
      rem -= c * d;
    end
    // results go out smallest denomination first, so the largest one used is last
    n = 0; last_k = 0;
    for (int k = m - 1; k >= 0; k--)
      if (used[k] > 0) last_k = k;
    for (int k = m - 1; k >= 0; k--)
      if (used[k] > 0)
        enqueue_payout(payout(bccmc_pkg::ST_OK, inv_value[order[k]], used[k][15:0], 1'b0,
                              k == last_k));
  endtask

  task automatic predict_inventory_op(input coin_req_t r);
    int s, v;
    case (r.op)
      bccmc_pkg::OP_ADD: begin
        s = find_denom(r.denom);
        if (s < 0) begin
          for (int i = 0; i < bccmc_pkg::NUM_SLOTS; i++)
            if (!inv_valid[i] && s < 0) s = i;
          if (s >= 0) begin
            inv_valid[s] = 1; inv_value[s] = r.denom; inv_stock[s] = 0;
          end
        end
        if (s < 0) begin
          enqueue_payout(payout(bccmc_pkg::ST_FULL, r.denom, 0, 1'b0, 1'b1));
        end else begin
          v = int'(inv_stock[s]) + int'(r.delta);
          if (v < 0) v = 0;
          if (v > 65535) v = 65535;
          inv_stock[s] = v[15:0];
          enqueue_payout(payout(bccmc_pkg::ST_OK, r.denom, v[15:0], 1'b0, 1'b1));
        end
      end
      bccmc_pkg::OP_QUERY: begin
        s = find_denom(r.denom);
        enqueue_payout(payout(bccmc_pkg::ST_OK, r.denom, s < 0 ? 16'd0 : inv_stock[s],
                              1'b0, 1'b1));
      end
      bccmc_pkg::OP_CHANGE: predict_change(r.amount);
      default: ;
    endcase
  endtask

  // driver
  coin_req_t cur_req;
  int        send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_valid && s_ready) predict_inventory_op(cur_req);
      if (!s_valid || s_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_valid <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain && expected_payouts.size() > 0)) begin
          cur_req = pending_reqs.pop_front();
          s_data  <= {cur_req.amount, cur_req.delta, cur_req.denom};
          s_user  <= cur_req.op;
          s_valid <= 1'b1;
          send_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int  recv_stall = 0;
  int  payouts_seen = 0;
  bit  long_hold_done = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    payout_t e;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        payouts_seen++;
        if (expected_payouts.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer data=%h user=%h", m_data, m_user));
        end else begin
          e = expected_payouts.pop_front();
          if (m_user[1:0] !== e.status || m_data[15:0] !== e.value ||
              m_data[31:16] !== e.count || m_user[2] !== e.no_coins || m_last !== e.last)
            report_mismatch($sformatf(
              "got st=%0d val=%0d cnt=%0d nc=%0d last=%0d exp st=%0d val=%0d cnt=%0d nc=%0d last=%0d",
              m_user[1:0], m_data[15:0], m_data[31:16], m_user[2], m_last,
              e.status, e.value, e.count, e.no_coins, e.last));
        end
        recv_stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
        if (!long_hold_done && payouts_seen == 30) begin
          recv_stall = 400;
          long_hold_done = 1;
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  task automatic queue_req(input logic [1:0] op, input logic [15:0] denom,
                           input logic signed [15:0] delta, input logic [15:0] amount,
                           input bit drain = 0);
    coin_req_t r;
    r.op = op; r.denom = denom; r.delta = delta; r.amount = amount; r.drain = drain;
    pending_reqs = {pending_reqs, r};
  endtask

  initial begin
    logic [15:0] pool[8];
    int sel;
    pool = '{16'd1, 16'd3, 16'd7, 16'd12, 16'd40000, 16'd25535, 16'd65535, 16'd0};
    for (int i = 0; i < bccmc_pkg::NUM_SLOTS; i++) begin
      inv_valid[i] = 0; inv_value[i] = 0; inv_stock[i] = 0;
    end
    // directed: large amount with large coins only, then edge cases
    queue_req(bccmc_pkg::OP_ADD, 16'd40000, 16'sd1, 16'd0);
    queue_req(bccmc_pkg::OP_ADD, 16'd25535, 16'sd1, 16'hFFFF);
    queue_req(bccmc_pkg::OP_CHANGE, 16'hFFFF, 16'sd0, 16'd65535);
    queue_req(bccmc_pkg::OP_CHANGE, 16'd0, -16'sd1, 16'd65534);
    queue_req(bccmc_pkg::OP_CHANGE, 16'd0, 16'sd0, 16'd0);
    queue_req(bccmc_pkg::OP_ADD, 16'd65535, -16'sd5, 16'd0);
    queue_req(bccmc_pkg::OP_QUERY, 16'd65535, 16'sd0, 16'd0);
    queue_req(bccmc_pkg::OP_QUERY, 16'd9, 16'sd0, 16'd0);
    queue_req(bccmc_pkg::OP_ADD, 16'd0, 16'sd3, 16'd0);
    queue_req(bccmc_pkg::OP_QUERY, 16'd0, 16'sd0, 16'd0);
    queue_req(bccmc_pkg::OP_ADD, 16'd1, 16'sd32767, 16'd0);
    queue_req(bccmc_pkg::OP_ADD, 16'd1, 16'sd32767, 16'd0);
    queue_req(bccmc_pkg::OP_ADD, 16'd1, -16'sd32768, 16'd0);
    queue_req(bccmc_pkg::OP_ADD, 16'd1, 16'sd32767, 16'd0);
    queue_req(bccmc_pkg::OP_ADD, 16'd3, 16'sd2, 16'd0);
    queue_req(bccmc_pkg::OP_CHANGE, 16'd0, 16'sd0, 16'd7);
    queue_req(OP_UNUSED, 16'hFFFF, -16'sd1, 16'hFFFF);
    queue_req(bccmc_pkg::OP_QUERY, 16'd1, 16'sd0, 16'd0, 1);
    queue_req(bccmc_pkg::OP_ADD, 16'd7, 16'sd1, 16'd0);
    queue_req(bccmc_pkg::OP_ADD, 16'd12, 16'sd4, 16'd0);
    queue_req(bccmc_pkg::OP_ADD, 16'd99, 16'sd4, 16'd0);
    queue_req(bccmc_pkg::OP_CHANGE, 16'd0, 16'sd0, 16'd26);
    // random: mostly pool denominations and small amounts to bound the search
    for (int n = 0; n < 80; n++) begin
      sel = $urandom_range(0, 9);
      if (sel < 4)
        queue_req(bccmc_pkg::OP_ADD,
                  ($urandom_range(0, 7) == 0) ? 16'($urandom) : pool[$urandom_range(0, 7)],
                  ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                              : 16'($signed($urandom_range(0, 12)) - 4),
                  16'($urandom), n == 60);
      else if (sel < 6)
        queue_req(bccmc_pkg::OP_QUERY,
                  ($urandom_range(0, 3) == 0) ? 16'($urandom) : pool[$urandom_range(0, 7)],
                  16'($urandom), 16'($urandom));
      else if (sel < 9)
        queue_req(bccmc_pkg::OP_CHANGE, 16'($urandom), 16'($urandom),
                  16'($urandom_range(0, 120)));
      else
        queue_req(OP_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom));
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_reqs.size() > 0 || s_valid || expected_payouts.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (expected_payouts.size() > 0) report_mismatch("results still outstanding");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #400000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// File: bounded_coin_change_min_coins.f
design/bccmc_pkg.sv
design/bccmc_div.sv
design/bccmc_dpath.sv
design/bccmc_ctrl.sv
design/bounded_coin_change_min_coins.sv
design/bccmc_checker.sv
tb/bounded_coin_change_min_coins_tb.sv
